// File: design/rpfa_pkg.sv
// package for the radial pair force accumulator: word types, codes, constants
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package rpfa_pkg;

  localparam int NumAlphaDefault    = 8;
  localparam int MaxTypesDefault    = 4;
  localparam int MaxParticlesDefault = 256;

  localparam logic [2:0] CMD_LOAD_TABLE = 3'd0;
  localparam logic [2:0] CMD_LOAD_GRAD  = 3'd1;
  localparam logic [2:0] CMD_PAIR       = 3'd2;
  localparam logic [2:0] CMD_READ       = 3'd3;
  localparam logic [2:0] CMD_ZERO       = 3'd4;

  localparam logic signed [31:0] ONE_Q16   = 32'sd65536;
  localparam logic [31:0]        LOG2E_Q30 = 32'd1549082005;

  typedef struct packed {
    logic [2:0]         cmd;
    logic [7:0]         slot;
    logic signed [31:0] value_a;
    logic signed [31:0] value_b;
    logic [7:0]         central_index;
    logic [7:0]         neighbor_index;
    logic [1:0]         neighbor_type;
    logic signed [31:0] descriptor;
    logic signed [31:0] deriv_x;
    logic signed [31:0] deriv_y;
    logic signed [31:0] deriv_z;
  } in_word_t;

  typedef struct packed {
    logic [7:0]         particle_out;
    logic signed [47:0] force_x;
    logic signed [47:0] force_y;
    logic signed [47:0] force_z;
  } out_word_t;

  // 2^f polynomial coefficients, Q30
  function automatic logic [31:0] pow2_coef(input logic [2:0] k);
    case (k)
      3'd0:    pow2_coef = 32'd744261118;
      3'd1:    pow2_coef = 32'd257941248;
      3'd2:    pow2_coef = 32'd59597083;
      3'd3:    pow2_coef = 32'd10327387;
      3'd4:    pow2_coef = 32'd1431680;
      3'd5:    pow2_coef = 32'd165394;
      3'd6:    pow2_coef = 32'd16378;
      default: pow2_coef = 32'd0;
    endcase
  endfunction

endpackage
`default_nettype wire

// File: design/radial_pair_force_accumulator_top.sv
// radial pair force accumulator: tables, gradient, force memory and sequencer
// depends on rpfa_pkg
//
// channel | dir | payload    | handshake
// in      | in  | in_word_t  | in_valid / in_ready
// out     | out | out_word_t | out_valid / out_ready
//
// load and zero words are written while idle; a read steps through the row read,
// the wait and the output register plus any output stall; a pair runs on the one shared
// 33x32 multiplier that runs every product of each term, the exp polynomial
// and the two-step force product (low 16 bits of the weight, then the rest).
// after reset a clearing pass over all MAX_PARTICLES rows zeroes the force memory,
// in_ready is low during it. a read result is held in an output register
// until taken; the next word is not accepted until then.
`timescale 1ns / 1ps
`default_nettype none
module radial_pair_force_accumulator_top
  import rpfa_pkg::*;
#(
  parameter int NUM_ALPHA     = NumAlphaDefault,
  parameter int MAX_TYPES     = MaxTypesDefault,
  parameter int MAX_PARTICLES = MaxParticlesDefault
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_word_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_word_t      out_data
);

  localparam int TableDepth = MAX_TYPES * NUM_ALPHA;
  localparam int TW = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int GW = (NUM_ALPHA > 1) ? $clog2(NUM_ALPHA) : 1;
  localparam int PW = $clog2(MAX_PARTICLES);

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_RD, S_RD_WAIT, S_OUT,
    S_T_FETCH, S_T_AX, S_T_EXPY, S_T_POLY, S_T_POW, S_T_CE, S_T_P1,
    S_T_P2, S_T_ACC, S_F_READ, S_F_WAIT, S_F_MUL, S_F_HI, S_F_WRITE
  } state_t;

  state_t state;

  // storage
  logic signed [31:0] alpha_mem [TableDepth];
  logic signed [31:0] coef_mem  [TableDepth];
  logic signed [31:0] grad_mem  [NUM_ALPHA];
  logic [143:0]       force_mem [MAX_PARTICLES];

  in_word_t           word;
  logic [GW:0]        term;
  logic [PW:0]        clr_cnt;
  logic signed [31:0] ta, tc, tg, x, onepx, tval, e;
  logic signed [47:0] w;
  logic [29:0]        frac;
  logic [5:0]         ip;
  logic [31:0]        poly;
  logic [2:0]         pk;
  logic [1:0]         comp;
  logic               pass;   // 0 neighbor, 1 central
  logic [143:0]       frow;
  logic signed [47:0] delta;
  logic signed [64:0] plo;    // low part of the weight times derivative

  // shared multiplier: signed 33 x 32, exact
  logic signed [32:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [64:0] prod;
  assign prod = mul_a * mul_b;

  // full product: the force step adds the high part to the held low part
  logic signed [79:0] pfull;
  assign pfull = (state == S_F_HI) ? ((80'(prod) <<< 16) + 80'(plo)) : 80'(prod);

  // rounding of the product/2^16 half away from zero
  logic               pneg;
  logic [79:0]        pmag, rmag;
  assign pneg = pfull[79];
  assign pmag = pneg ? 80'(-pfull) : 80'(pfull);
  assign rmag = (pmag + 80'h8000) >> 16;

  function automatic logic signed [47:0] sat_mag(input logic [79:0] m,
                                                input logic neg,
                                                input int bits);
    logic [79:0] lim;
    logic [79:0] v;
    lim = (80'd1 << (bits - 1)) - (neg ? 80'd0 : 80'd1);
    v = (m > lim) ? lim : m;
    sat_mag = neg ? 48'(-v) : 48'(v);
  endfunction

  function automatic logic signed [47:0] sat48(input logic signed [49:0] v);
    if (v > 50'sh0_7FFF_FFFF_FFFF)       sat48 = 48'sh7FFF_FFFF_FFFF;
    else if (v < -50'sh0_8000_0000_0000) sat48 = 48'sh8000_0000_0000;
    else                                 sat48 = v[47:0];
  endfunction

  logic signed [31:0] q32;
  logic signed [47:0] q48;
  assign q32 = 32'(sat_mag(rmag, pneg, 32));
  assign q48 = sat_mag(rmag, pneg, 48);

  // exp: clamp of the argument to [-16, 11]
  logic signed [31:0] xc;
  assign xc = (x < -32'sd1048576) ? -32'sd1048576 :
              (x > 32'sd720896) ? 32'sd720896 : x;

  // derivative component for the force product
  logic signed [31:0] dsel;
  always_comb begin
    case (comp)
      2'd0:    dsel = word.deriv_x;
      2'd1:    dsel = word.deriv_y;
      default: dsel = word.deriv_z;
    endcase
  end

  // multiplier operand select
  logic [GW-1:0] tix;
  assign tix = term[GW-1:0];
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_T_AX:   begin mul_a = 33'(ta);   mul_b = word.descriptor; end
      S_T_EXPY: begin mul_a = 33'(xc);   mul_b = LOG2E_Q30;       end
      S_T_POLY: begin mul_a = 33'(poly); mul_b = 32'({2'b00, frac}); end
      S_T_CE:   begin mul_a = 33'(tc);   mul_b = e;               end
      S_T_P1:   begin mul_a = 33'(tval); mul_b = onepx;           end
      S_T_P2:   begin mul_a = 33'(tval); mul_b = tg;              end
      S_F_MUL:  begin mul_a = 33'({1'b0, w[15:0]});      mul_b = dsel; end
      S_F_HI:   begin mul_a = 33'($signed(w[47:16]));    mul_b = dsel; end
      default: ;
    endcase
  end

  // exp: log2 scale
  logic [63:0] ybits;
  assign ybits = 64'(prod) + (64'd1 << 51);

  // final 2^n scaling of m
  logic [31:0] m;
  logic [63:0] pw_res;
  logic [5:0]  sh;
  assign m = 32'(poly);
  always_comb begin
    sh = 6'd46 - ip;
    if (ip >= 6'd46) pw_res = 64'(m) << (ip - 6'd46);
    else             pw_res = (64'(m) + (64'd1 << (sh - 6'd1))) >> sh;
  end

  // force row read
  logic [PW-1:0] frd_addr;
  always_comb begin
    if (state == S_RD) frd_addr = word.slot[PW-1:0];
    else frd_addr = pass ? word.central_index[PW-1:0] : word.neighbor_index[PW-1:0];
  end

  logic signed [47:0] fcomp, fnew;
  always_comb begin
    case (comp)
      2'd0:    fcomp = frow[143:96];
      2'd1:    fcomp = frow[95:48];
      default: fcomp = frow[47:0];
    endcase
    fnew = pass ? sat48(50'(fcomp) - 50'(delta)) : sat48(50'(fcomp) + 50'(delta));
  end

  logic [143:0] frow_upd;
  always_comb begin
    frow_upd = frow;
    case (comp)
      2'd0:    frow_upd[143:96] = fnew;
      2'd1:    frow_upd[95:48]  = fnew;
      default: frow_upd[47:0]   = fnew;
    endcase
  end

  // storage writes and registered read
  always_ff @(posedge clk) begin
    if (state == S_CLEAR) force_mem[clr_cnt[PW-1:0]] <= '0;
    if (state == S_F_WRITE && comp == 2'd2) force_mem[frd_addr] <= frow_upd;
    if (state == S_IDLE && in_valid && in_data.cmd == CMD_ZERO &&
        32'(in_data.slot) < MAX_PARTICLES)
      force_mem[in_data.slot[PW-1:0]] <= '0;
    if (state == S_IDLE && in_valid && in_data.cmd == CMD_LOAD_TABLE &&
        32'(in_data.slot) < TableDepth) begin
      alpha_mem[in_data.slot[TW-1:0]] <= in_data.value_a;
      coef_mem[in_data.slot[TW-1:0]]  <= in_data.value_b;
    end
    if (state == S_IDLE && in_valid && in_data.cmd == CMD_LOAD_GRAD &&
        32'(in_data.slot) < NUM_ALPHA)
      grad_mem[in_data.slot[GW-1:0]] <= in_data.value_a;
    if (state == S_T_FETCH) begin
      ta <= alpha_mem[TW'(32'(word.neighbor_type) * NUM_ALPHA + 32'(tix))];
      tc <= coef_mem[TW'(32'(word.neighbor_type) * NUM_ALPHA + 32'(tix))];
      tg <= grad_mem[tix];
    end
    if (state == S_RD || state == S_F_READ) frow <= force_mem[frd_addr];
    else if (state == S_F_WRITE) frow <= frow_upd;
  end

  assign in_ready = (state == S_IDLE);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (32'(clr_cnt) == MAX_PARTICLES - 1) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid) begin
            word <= in_data;
            case (in_data.cmd)
              CMD_PAIR: begin
                if (32'(in_data.neighbor_type) < MAX_TYPES &&
                    32'(in_data.central_index) < MAX_PARTICLES &&
                    32'(in_data.neighbor_index) < MAX_PARTICLES) begin
                  term  <= '0;
                  w     <= '0;
                  state <= S_T_FETCH;
                end
              end
              CMD_READ: state <= S_RD;
              default: ;
            endcase
          end
        end
        S_RD: state <= S_RD_WAIT;
        S_RD_WAIT: begin
          out_data.particle_out <= word.slot;
          if (32'(word.slot) < MAX_PARTICLES) begin
            out_data.force_x <= frow[143:96];
            out_data.force_y <= frow[95:48];
            out_data.force_z <= frow[47:0];
          end else begin
            out_data.force_x <= '0;
            out_data.force_y <= '0;
            out_data.force_z <= '0;
          end
          out_valid <= 1'b1;
          state     <= S_OUT;
        end
        S_OUT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            state     <= S_IDLE;
          end
        end
        S_T_FETCH: state <= S_T_AX;
        S_T_AX: begin
          x     <= q32;
          onepx <= (q32 > 32'sh7FFE_FFFF) ? 32'sh7FFF_FFFF : q32 + ONE_Q16;
          state <= S_T_EXPY;
        end
        S_T_EXPY: begin
          // split the log2-scaled clamped argument into integer and fraction
          ip    <= ybits[51:46];
          frac  <= ybits[45:16];
          poly  <= pow2_coef(3'd6);
          pk    <= 3'd5;
          state <= S_T_POLY;
        end
        S_T_POLY: begin
          if (pk == 3'd7) begin
            poly  <= 32'h4000_0000 + 32'(prod[59:30]);
            state <= S_T_POW;
          end else begin
            poly <= pow2_coef(pk) + 32'(prod[61:30]);
            pk   <= pk - 3'd1;
          end
        end
        S_T_POW: begin
          e     <= (pw_res > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : 32'(pw_res);
          state <= S_T_CE;
        end
        S_T_CE: begin tval <= q32; state <= S_T_P1; end
        S_T_P1: begin tval <= q32; state <= S_T_P2; end
        S_T_P2: begin tval <= q32; state <= S_T_ACC; end
        S_T_ACC: begin
          w <= sat48(50'(w) + 50'(tval) * 50'sd128);
          if (32'(term) == NUM_ALPHA - 1) begin
            comp  <= 2'd0;
            pass  <= 1'b0;
            state <= S_F_READ;
          end else begin
            term  <= term + 1'b1;
            state <= S_T_FETCH;
          end
        end
        S_F_READ: begin comp <= 2'd0; state <= S_F_WAIT; end
        S_F_WAIT: state <= S_F_MUL;
        S_F_MUL: begin plo <= prod; state <= S_F_HI; end
        S_F_HI: begin delta <= q48; state <= S_F_WRITE; end
        S_F_WRITE: begin
          if (comp == 2'd2) begin
            if (pass) state <= S_IDLE;
            else begin
              pass  <= 1'b1;
              state <= S_F_READ;
            end
          end else begin
            comp  <= comp + 2'd1;
            state <= S_F_MUL;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // checks
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !out_valid) else $error("ready while result pending");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result dropped");
  a_read_out: assert property (@(posedge clk) disable iff (rst)
    state == S_RD_WAIT |=> out_valid) else $error("read without result");
  a_comp: assert property (@(posedge clk) disable iff (rst)
    state == S_F_MUL |-> comp != 2'd3) else $error("bad component");

endmodule
`default_nettype wire
